/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the keyed double-ended queue.
// Each macro expands to one labelled concurrent assertion on clk, reset by arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define KDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define KDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/kdq_pkg.sv */
// Shared constants for the keyed double-ended queue: action and status codes,
// stream field positions and widths. No dependencies.
`default_nettype none
package kdq_pkg;
	localparam int ACTION_W = 4;
	localparam int FIELD_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 5;

	// Input stream word: action, key, data_in from bit 0 up, padded to bytes.
	localparam int IN_KEY_LO   = ACTION_W;
	localparam int IN_DATA_LO  = ACTION_W + FIELD_W;
	localparam int IN_USED_W   = ACTION_W + 2 * FIELD_W;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// Output stream word: status, data_out, key_out, count from bit 0 up.
	localparam int OUT_USED_W  = STATUS_W + 2 * FIELD_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_HEAD  = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_TAIL  = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_PEEK_HEAD = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_PEEK_TAIL = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_POP_KEY   = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_PEEK_KEY  = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_COUNT_KEY = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_FLUSH     = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;
endpackage
`default_nettype wire

/* hw/rtl/kdq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module kdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/keyed_double_ended_queue.sv */
// Keyed double-ended queue top level: sequencer, list registers and two slot RAMs.
// Depends on kdq_pkg, kdq_ram and assert_macros.svh.
//
// One request is taken at a time and gives one result. Pushes pass S_PUSH_A, and
// S_PUSH_B unless the queue was empty; head and tail pops and peeks pass S_FETCH
// and S_EVAL; flush, unused actions, refused pushes and any read of an empty queue
// go straight to S_RESULT. Keyed pops, peeks and key counts walk the list from the
// head one linked slot per cycle through the RAM read port, visiting at most DEPTH
// slots; a keyed pop that unlinks a slot from the middle of the list then passes
// S_LINK_R, S_LINK_A and S_LINK_B. A result waits in S_RESULT while an earlier one
// is held for m_tready, then sits in the output register while the next is accepted.
`default_nettype none
`include "assert_macros.svh"
module keyed_double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int KEY_WIDTH  = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// action [3:0], key [35:4], data_in [67:36], zero pad above
	input  wire logic [kdq_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// status [1:0], data_out [33:2], key_out [65:34], count [70:66], zero pad above
	output logic      [kdq_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [kdq_pkg::CFG_W-1:0]        cfg_wdata
);
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LKW = 2 * AW;
	localparam int EW  = KEY_WIDTH + DATA_WIDTH;
	localparam int MW  = (CW > kdq_pkg::CFG_W) ? CW : kdq_pkg::CFG_W;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_FETCH  = 9'b000000010,
		S_EVAL   = 9'b000000100,
		S_LINK_R = 9'b000001000,
		S_LINK_A = 9'b000010000,
		S_LINK_B = 9'b000100000,
		S_PUSH_A = 9'b001000000,
		S_PUSH_B = 9'b010000000,
		S_RESULT = 9'b100000000
	} state_t;

	state_t state_q;
	logic [AW-1:0]                 head_q, tail_q, slot_q, p_q, n_q;
	logic [CW-1:0]                 occ_q, idx_q, cnt_q;
	logic [DEPTH-1:0]              free_q;
	logic [kdq_pkg::CFG_W-1:0]     max_q;
	logic [kdq_pkg::ACTION_W-1:0]  action_q;
	logic [KEY_WIDTH-1:0]          key_q;
	logic [DATA_WIDTH-1:0]         data_q;
	logic [kdq_pkg::STATUS_W-1:0]  res_status_q, out_status_q;
	logic [DATA_WIDTH-1:0]         res_data_q;
	logic [KEY_WIDTH-1:0]          res_key_q;
	logic [kdq_pkg::FIELD_W-1:0]   out_data_q, out_key_q;
	logic [kdq_pkg::COUNT_W-1:0]   out_count_q;
	logic                          m_tvalid_q;

	logic [kdq_pkg::ACTION_W-1:0]  in_action;
	logic [kdq_pkg::FIELD_W-1:0]   in_key, in_data;
	logic                          acc, full, in_is_push, in_is_read, in_is_tail;
	logic [AW-1:0]                 first_free, rd_addr, nb_addr, wb_addr;
	logic [MW-1:0]                 max_ext, lim;
	logic [EW-1:0]                 rd_a;
	logic [LKW-1:0]                rd_b, wb_data;
	logic                          wb_en;
	logic [KEY_WIDTH-1:0]          rd_key;
	logic [DATA_WIDTH-1:0]         rd_data;
	logic [AW-1:0]                 rd_next, rd_prev;
	logic                          is_keyed, is_count, is_pop, match, last, found, out_free;

	assign in_action = s_tdata[kdq_pkg::ACTION_W-1:0];
	assign in_key    = s_tdata[kdq_pkg::IN_KEY_LO +: kdq_pkg::FIELD_W];
	assign in_data   = s_tdata[kdq_pkg::IN_DATA_LO +: kdq_pkg::FIELD_W];

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{kdq_pkg::OUT_PAD_W{1'b0}}, out_count_q, out_key_q, out_data_q,
		out_status_q};

	assign in_is_push = (in_action == kdq_pkg::ACT_PUSH_TAIL) ||
		(in_action == kdq_pkg::ACT_PUSH_HEAD);
	assign in_is_read = in_action inside {[kdq_pkg::ACT_POP_HEAD:kdq_pkg::ACT_COUNT_KEY]};
	assign in_is_tail = (in_action == kdq_pkg::ACT_POP_TAIL) ||
		(in_action == kdq_pkg::ACT_PEEK_TAIL);

	// Lowest free slot.
	always_comb begin
		first_free = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				first_free = AW'(i);
			end
		end
	end

	assign max_ext = MW'(max_q);
	assign lim     = (max_ext == '0 || max_ext > MW'(DEPTH)) ? MW'(DEPTH) : max_ext;
	assign full    = MW'(occ_q) >= lim;

	assign rd_key  = rd_a[EW-1:DATA_WIDTH];
	assign rd_data = rd_a[DATA_WIDTH-1:0];
	assign rd_next = rd_b[LKW-1:AW];
	assign rd_prev = rd_b[AW-1:0];

	assign is_keyed = (action_q == kdq_pkg::ACT_POP_KEY) ||
		(action_q == kdq_pkg::ACT_PEEK_KEY);
	assign is_count = (action_q == kdq_pkg::ACT_COUNT_KEY);
	assign is_pop   = (action_q == kdq_pkg::ACT_POP_HEAD) ||
		(action_q == kdq_pkg::ACT_POP_TAIL) || (action_q == kdq_pkg::ACT_POP_KEY);
	assign match    = (rd_key == key_q);
	assign last     = (idx_q == CW'(occ_q - 1'b1));
	assign found    = is_keyed ? match : !is_count;
	assign nb_addr  = (action_q == kdq_pkg::ACT_PUSH_TAIL) ? tail_q : head_q;

	// While walking, the next slot's read is issued straight from the link just read.
	always_comb begin
		case (state_q)
			S_EVAL:   rd_addr = rd_next;
			S_LINK_R: rd_addr = p_q;
			S_LINK_A: rd_addr = n_q;
			S_PUSH_A: rd_addr = nb_addr;
			default:  rd_addr = slot_q;
		endcase
	end

	always_comb begin
		wb_en   = 1'b0;
		wb_addr = slot_q;
		wb_data = '0;
		case (state_q)
			S_PUSH_A: begin
				wb_en = 1'b1;
				if (occ_q == '0) begin
					wb_data = '0;
				end else if (action_q == kdq_pkg::ACT_PUSH_TAIL) begin
					wb_data = {{AW{1'b0}}, tail_q};
				end else begin
					wb_data = {head_q, {AW{1'b0}}};
				end
			end
			S_PUSH_B: begin
				wb_en   = 1'b1;
				wb_addr = nb_addr;
				wb_data = (action_q == kdq_pkg::ACT_PUSH_TAIL) ? {slot_q, rd_prev} :
					{rd_next, slot_q};
			end
			S_LINK_A: begin
				wb_en   = 1'b1;
				wb_addr = p_q;
				wb_data = {n_q, rd_prev};
			end
			S_LINK_B: begin
				wb_en   = 1'b1;
				wb_addr = n_q;
				wb_data = {rd_next, p_q};
			end
			default: begin
				wb_en = 1'b0;
			end
		endcase
	end

	kdq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (state_q == S_PUSH_A),
		.waddr (slot_q),
		.wdata ({key_q, data_q}),
		.raddr (rd_addr),
		.rdata (rd_a)
	);

	kdq_ram #(.WIDTH(LKW), .DEPTH(DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (wb_en),
		.waddr (wb_addr),
		.wdata (wb_data),
		.raddr (rd_addr),
		.rdata (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			free_q     <= '1;
			max_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (state_q == S_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (in_is_push) begin
							state_q <= full ? S_RESULT : S_PUSH_A;
						end else if (in_is_read) begin
							state_q <= (occ_q == '0) ? S_RESULT : S_FETCH;
						end else begin
							if (in_action == kdq_pkg::ACT_FLUSH) begin
								free_q <= '1;
								occ_q  <= '0;
								head_q <= '0;
								tail_q <= '0;
							end
							state_q <= S_RESULT;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (found) begin
						if (is_pop) begin
							free_q[slot_q] <= 1'b1;
							if (occ_q <= CW'(1)) begin
								occ_q   <= '0;
								state_q <= S_RESULT;
							end else begin
								occ_q <= CW'(occ_q - 1'b1);
								if (slot_q == head_q) begin
									head_q  <= rd_next;
									state_q <= S_RESULT;
								end else if (slot_q == tail_q) begin
									tail_q  <= rd_prev;
									state_q <= S_RESULT;
								end else begin
									state_q <= S_LINK_R;
								end
							end
						end else begin
							state_q <= S_RESULT;
						end
					end else if (last) begin
						state_q <= S_RESULT;
					end
				end
				S_LINK_R: begin
					state_q <= S_LINK_A;
				end
				S_LINK_A: begin
					state_q <= S_LINK_B;
				end
				S_LINK_B: begin
					state_q <= S_RESULT;
				end
				S_PUSH_A: begin
					free_q[slot_q] <= 1'b0;
					occ_q          <= CW'(occ_q + 1'b1);
					if (occ_q == '0) begin
						head_q  <= slot_q;
						tail_q  <= slot_q;
						state_q <= S_RESULT;
					end else begin
						state_q <= S_PUSH_B;
					end
				end
				S_PUSH_B: begin
					if (action_q == kdq_pkg::ACT_PUSH_TAIL) begin
						tail_q <= slot_q;
					end else begin
						head_q <= slot_q;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					action_q   <= in_action;
					key_q      <= KEY_WIDTH'(in_key);
					data_q     <= DATA_WIDTH'(in_data);
					slot_q     <= in_is_push ? first_free : (in_is_tail ? tail_q : head_q);
					idx_q      <= '0;
					cnt_q      <= '0;
					res_data_q <= '0;
					res_key_q  <= '0;
					if (in_is_push && full) begin
						res_status_q <= kdq_pkg::ST_FULL;
					end else if (in_is_read && in_action != kdq_pkg::ACT_COUNT_KEY &&
						occ_q == '0) begin
						res_status_q <= kdq_pkg::ST_EMPTY;
					end else begin
						res_status_q <= kdq_pkg::ST_OK;
					end
				end
			end
			S_EVAL: begin
				p_q <= rd_prev;
				n_q <= rd_next;
				if (is_count) begin
					cnt_q <= CW'(cnt_q + CW'(match));
				end
				if (found) begin
					res_data_q <= rd_data;
					res_key_q  <= rd_key;
				end else if (last) begin
					if (is_keyed) begin
						res_status_q <= kdq_pkg::ST_NOT_FOUND;
					end
				end else begin
					slot_q <= rd_next;
					idx_q  <= CW'(idx_q + 1'b1);
				end
			end
			S_RESULT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_data_q   <= kdq_pkg::FIELD_W'(res_data_q);
					out_key_q    <= kdq_pkg::FIELD_W'(res_key_q);
					out_count_q  <= is_count ? kdq_pkg::COUNT_W'(cnt_q) :
						kdq_pkg::COUNT_W'(occ_q);
				end
			end
			default: begin
			end
		endcase
	end

	`KDQ_ASSERT(a_occ_bound, occ_q <= CW'(DEPTH), "occupancy above depth")
	`KDQ_ASSERT(a_free_match, $countones(free_q) + int'(occ_q) == DEPTH,
		"free slot map disagrees with occupancy")
	`KDQ_ASSERT_NEXT(a_result_src, !m_tvalid_q && state_q != S_RESULT, !m_tvalid_q,
		"result raised outside the result state")
endmodule
`default_nettype wire
